@@ hdl/gutld_pkg.sv @@
// gutld_pkg: shared types, widths and calendar helpers for the utc to local
// date/time converter. no dependencies.

package gutld_pkg;

   localparam int TEXT_W   = 48;
   localparam int OFFSET_W = 5;
   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int HOUR_W   = 5;
   localparam int MINSEC_W = 6;
   localparam int TWO_W    = 7;
   localparam int HSUM_W   = 7;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;
   localparam logic [YEAR_W-1:0]   YEAR_BASE    = 12'd2000;
   localparam logic [HOUR_W-1:0]   HOURS_PER_DAY = 5'd24;
   localparam logic [MINSEC_W-1:0] MINSEC_MAX   = 6'd59;
   localparam logic [HOUR_W-1:0]   HOUR_MAX     = 5'd23;
   localparam logic [MONTH_W-1:0]  MONTH_JAN    = 4'd1;
   localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
   localparam logic [MONTH_W-1:0]  MONTH_DEC    = 4'd12;
   localparam logic [DAY_W-1:0]    DAYS_DEC     = 5'd31;

   // stage 1: decoded two-digit fields
   typedef struct packed {
      logic [TWO_W-1:0]           day;
      logic [TWO_W-1:0]           month;
      logic [TWO_W-1:0]           yy;
      logic [TWO_W-1:0]           hour;
      logic [TWO_W-1:0]           minute;
      logic [TWO_W-1:0]           second;
      logic                       digits_ok;
      logic signed [OFFSET_W-1:0] offset;
   } decode_type;

   // stage 2: checked fields, shifted hour and month lengths
   typedef struct packed {
      logic [DAY_W-1:0]         day;
      logic [MONTH_W-1:0]       month;
      logic [TWO_W-1:0]         yy;
      logic signed [HSUM_W-1:0] hour_sum;
      logic [MINSEC_W-1:0]      minute;
      logic [MINSEC_W-1:0]      second;
      logic [DAY_W-1:0]         days_cur;
      logic [DAY_W-1:0]         days_prev;
      logic                     ok;
   } adjust_type;

   typedef struct packed {
      logic [DAY_W-1:0]    local_day;
      logic [MONTH_W-1:0]  local_month;
      logic [YEAR_W-1:0]   local_year;
      logic [HOUR_W-1:0]   local_hour;
      logic [MINSEC_W-1:0] local_minute;
      logic [MINSEC_W-1:0] local_second;
      logic                input_ok;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // tens*10 + ones from the low nibbles of two ascii digits
   function automatic logic [TWO_W-1:0] two_digit(input logic [7:0] hi, input logic [7:0] lo);
      logic [TWO_W-1:0] t;
      t = {3'b000, hi[3:0]};
      return (t << 3) + (t << 1) + {3'b000, lo[3:0]};
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
         4'd2:                                      d = leap ? 5'd29 : 5'd28;
         default:                                   d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

@@ hdl/gutld_if.sv @@
// gutld_req_if / gutld_rsp_if: valid/ready channels for the converter.
// depends on gutld_pkg for field widths.

interface gutld_req_if;
   logic                         valid;
   logic                         ready;
   logic [gutld_pkg::TEXT_W-1:0] date_text;
   logic [gutld_pkg::TEXT_W-1:0] time_text;

   modport source (output valid, output date_text, output time_text, input ready);
   modport sink   (input valid, input date_text, input time_text, output ready);
endinterface

interface gutld_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gutld_pkg::DAY_W-1:0]    local_day;
   logic [gutld_pkg::MONTH_W-1:0]  local_month;
   logic [gutld_pkg::YEAR_W-1:0]   local_year;
   logic [gutld_pkg::HOUR_W-1:0]   local_hour;
   logic [gutld_pkg::MINSEC_W-1:0] local_minute;
   logic [gutld_pkg::MINSEC_W-1:0] local_second;
   logic                           input_ok;

   modport source (output valid, output local_day, output local_month, output local_year,
                   output local_hour, output local_minute, output local_second,
                   output input_ok, input ready);
   modport sink   (input valid, input local_day, input local_month, input local_year,
                   input local_hour, input local_minute, input local_second,
                   input input_ok, output ready);
endinterface

@@ hdl/gutld_carry.sv @@
// gutld_carry: applies the day/month/year carry after the hour shift and
// zeroes invalid transactions. depends on gutld_pkg.

module gutld_carry (
   input  gutld_pkg::adjust_type adj,
   output gutld_pkg::result_type res
);

   logic [gutld_pkg::YEAR_W-1:0]   year;
   logic [gutld_pkg::DAY_W-1:0]    day;
   logic [gutld_pkg::MONTH_W-1:0]  month;
   logic [gutld_pkg::YEAR_W-1:0]   year_out;
   logic [gutld_pkg::HSUM_W-1:0]   hour_adj;
   logic                           under;
   logic                           over;

   assign year  = gutld_pkg::YEAR_BASE + {5'b00000, adj.yy};
   assign under = adj.hour_sum < 0;
   assign over  = adj.hour_sum >= $signed({2'b00, gutld_pkg::HOURS_PER_DAY});

   always_comb begin
      day      = adj.day;
      month    = adj.month;
      year_out = year;
      hour_adj = adj.hour_sum;
      if (under) begin
         hour_adj = adj.hour_sum + {2'b00, gutld_pkg::HOURS_PER_DAY};
         if (adj.day == 5'd1) begin
            if (adj.month == gutld_pkg::MONTH_JAN) begin
               month    = gutld_pkg::MONTH_DEC;
               year_out = year - 12'd1;
               day      = gutld_pkg::DAYS_DEC;
            end else begin
               month = adj.month - 4'd1;
               day   = adj.days_prev;
            end
         end else begin
            day = adj.day - 5'd1;
         end
      end else if (over) begin
         hour_adj = adj.hour_sum - {2'b00, gutld_pkg::HOURS_PER_DAY};
         if (adj.day == adj.days_cur) begin
            day = 5'd1;
            if (adj.month == gutld_pkg::MONTH_DEC) begin
               month    = gutld_pkg::MONTH_JAN;
               year_out = year + 12'd1;
            end else begin
               month = adj.month + 4'd1;
            end
         end else begin
            day = adj.day + 5'd1;
         end
      end
   end

   always_comb begin
      if (adj.ok) begin
         res.local_day    = day;
         res.local_month  = month;
         res.local_year   = year_out;
         res.local_hour   = hour_adj[gutld_pkg::HOUR_W-1:0];
         res.local_minute = adj.minute;
         res.local_second = adj.second;
         res.input_ok     = 1'b1;
      end else begin
         res = '0;
      end
   end

endmodule

@@ hdl/gps_utc_to_local_datetime_top.sv @@
// utc to local date/time converter, three register stages: digit decode,
// range check and hour shift, carry into the output register.
// a request passes through s1_ff, s2_ff and s3_ff before its response is valid.
// throughput: one transaction per cycle; each stage stalls only when full and
// blocked downstream, so bubbles are squeezed out while a response waits.
// reset (synchronous) clears all stage valid bits and the zone offset to 0.

module gps_utc_to_local_datetime_top (
   input  logic                                   clock,
   input  logic                                   reset,
   gutld_req_if.sink                              req_bus,
   gutld_rsp_if.source                            rsp_bus,
   input  logic                                   csr_wr_en,
   input  logic signed [gutld_pkg::OFFSET_W-1:0]  csr_wr_data
);

   logic signed [gutld_pkg::OFFSET_W-1:0] offset_ff;

   logic                    s1_valid_ff, s1_valid_in;
   gutld_pkg::decode_type   s1_ff, s1_in;
   logic                    s2_valid_ff, s2_valid_in;
   gutld_pkg::adjust_type   s2_ff, s2_in;
   logic                    s3_valid_ff, s3_valid_in;
   gutld_pkg::result_type   s3_ff, s3_in;

   logic rdy1, rdy2, rdy3;
   logic leap;
   logic [gutld_pkg::MONTH_W-1:0] mon_n;

   assign rdy3 = !s3_valid_ff || rsp_bus.ready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= gutld_pkg::OFFSET_RESET;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   // stage 1: ascii decode
   always_comb begin
      s1_in.day    = gutld_pkg::two_digit(req_bus.date_text[47:40], req_bus.date_text[39:32]);
      s1_in.month  = gutld_pkg::two_digit(req_bus.date_text[31:24], req_bus.date_text[23:16]);
      s1_in.yy     = gutld_pkg::two_digit(req_bus.date_text[15:8],  req_bus.date_text[7:0]);
      s1_in.hour   = gutld_pkg::two_digit(req_bus.time_text[47:40], req_bus.time_text[39:32]);
      s1_in.minute = gutld_pkg::two_digit(req_bus.time_text[31:24], req_bus.time_text[23:16]);
      s1_in.second = gutld_pkg::two_digit(req_bus.time_text[15:8],  req_bus.time_text[7:0]);
      s1_in.digits_ok = 1'b1;
      for (int i = 0; i < 6; i++) begin
         if (!gutld_pkg::is_digit(req_bus.date_text[i*8 +: 8]) ||
             !gutld_pkg::is_digit(req_bus.time_text[i*8 +: 8])) begin
            s1_in.digits_ok = 1'b0;
         end
      end
      s1_in.offset = offset_ff;
      s1_valid_in  = rdy1 ? req_bus.valid : s1_valid_ff;
   end

   // stage 2: range check, month lengths, hour shift
   // years 2000..2099 only, so leap is just yy divisible by 4
   assign leap  = (s1_ff.yy[1:0] == 2'b00);
   assign mon_n = s1_ff.month[gutld_pkg::MONTH_W-1:0];

   always_comb begin
      s2_in.day       = s1_ff.day[gutld_pkg::DAY_W-1:0];
      s2_in.month     = mon_n;
      s2_in.yy        = s1_ff.yy;
      s2_in.hour_sum  = $signed({2'b00, s1_ff.hour[gutld_pkg::HOUR_W-1:0]})
                        + {{(gutld_pkg::HSUM_W-gutld_pkg::OFFSET_W){s1_ff.offset[4]}},
                           s1_ff.offset};
      s2_in.minute    = s1_ff.minute[gutld_pkg::MINSEC_W-1:0];
      s2_in.second    = s1_ff.second[gutld_pkg::MINSEC_W-1:0];
      s2_in.days_cur  = gutld_pkg::month_days(mon_n, leap);
      s2_in.days_prev = gutld_pkg::month_days(mon_n - 4'd1, leap);
      s2_in.ok = s1_ff.digits_ok &&
                 (s1_ff.month >= 7'd1) && (s1_ff.month <= 7'd12) &&
                 (s1_ff.day >= 7'd1) &&
                 (s1_ff.day <= {2'b00, gutld_pkg::month_days(mon_n, leap)}) &&
                 (s1_ff.hour <= {2'b00, gutld_pkg::HOUR_MAX}) &&
                 (s1_ff.minute <= {1'b0, gutld_pkg::MINSEC_MAX}) &&
                 (s1_ff.second <= {1'b0, gutld_pkg::MINSEC_MAX});
      s2_valid_in = rdy2 ? s1_valid_ff : s2_valid_ff;
   end

   // stage 3: carry and output register
   gutld_carry u_carry (
      .adj (s2_ff),
      .res (s3_in)
   );

   assign s3_valid_in = rdy3 ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_bus.valid        = s3_valid_ff;
   assign rsp_bus.local_day    = s3_ff.local_day;
   assign rsp_bus.local_month  = s3_ff.local_month;
   assign rsp_bus.local_year   = s3_ff.local_year;
   assign rsp_bus.local_hour   = s3_ff.local_hour;
   assign rsp_bus.local_minute = s3_ff.local_minute;
   assign rsp_bus.local_second = s3_ff.local_second;
   assign rsp_bus.input_ok     = s3_ff.input_ok;

endmodule

@@ hdl/gutld_checker.sv @@
// gutld_checker: port-level checks on the converter's response channel,
// bound to gps_utc_to_local_datetime_top. depends on gutld_pkg widths.

module gutld_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gutld_pkg::DAY_W-1:0]    local_day,
   input logic [gutld_pkg::MONTH_W-1:0]  local_month,
   input logic [gutld_pkg::YEAR_W-1:0]   local_year,
   input logic [gutld_pkg::HOUR_W-1:0]   local_hour,
   input logic [gutld_pkg::MINSEC_W-1:0] local_minute,
   input logic [gutld_pkg::MINSEC_W-1:0] local_second,
   input logic                           input_ok
);

   // a stalled response holds its day, month, year, hour and input_ok
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(local_day) && $stable(local_month)
      && $stable(local_year) && $stable(local_hour) && $stable(input_ok))
      else $error("stalled response changed");

   // rejected transactions give all-zero fields
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !input_ok |-> local_day == 0 && local_month == 0 && local_year == 0
      && local_hour == 0 && local_minute == 0 && local_second == 0)
      else $error("invalid transaction with nonzero fields");

   // good transactions have day >= 1, month 1..12 and a legal clock time
   a_good_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && input_ok |-> local_day >= 1 && local_month >= 1 && local_month <= 12
      && local_hour <= 23 && local_minute <= 59 && local_second <= 59)
      else $error("local date/time out of range");

   // carry never leaves 1999..2100
   a_year_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && input_ok |-> local_year >= 12'd1999 && local_year <= 12'd2100)
      else $error("local year out of range");

endmodule

bind gps_utc_to_local_datetime_top gutld_checker u_gutld_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .local_day    (rsp_bus.local_day),
   .local_month  (rsp_bus.local_month),
   .local_year   (rsp_bus.local_year),
   .local_hour   (rsp_bus.local_hour),
   .local_minute (rsp_bus.local_minute),
   .local_second (rsp_bus.local_second),
   .input_ok     (rsp_bus.input_ok)
);

@@ tb/gps_utc_to_local_datetime_top_tb.sv @@
`timescale 1ns / 1ps
// testbench for gps_utc_to_local_datetime_top: directed and random date/time
// transactions under several zone offsets, checked by a scoreboard class.
// depends on gutld_pkg and the gutld_req_if / gutld_rsp_if interfaces.

class tz_scoreboard;
   gutld_pkg::result_type due_q[$];
   logic signed [gutld_pkg::OFFSET_W-1:0] zone;
   int errors;
   int checked;
   int good_inputs;
   int bad_inputs;
   int days_back;
   int days_fwd;

   function new();
      zone = '0;
   endfunction

   static function bit leap_year(int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   static function int month_length(int m, int y);
      int lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) return 0;
      if (m == 2 && leap_year(y)) return 29;
      return lengths[m-1];
   endfunction

   // expected local date/time for one utc transaction at the current offset
   function gutld_pkg::result_type localize(logic [47:0] dt, logic [47:0] tt);
      gutld_pkg::result_type r;
      logic [95:0] both;
      logic [7:0] ch_hi, ch_lo;
      int v[6];
      int k, day, mon, year, hour;
      bit ok;
      both = {dt, tt};
      ok = 1;
      r = '0;
      for (k = 0; k < 6; k++) begin
         ch_hi = both[95-16*k -: 8];
         ch_lo = both[87-16*k -: 8];
         if (ch_hi < 8'h30 || ch_hi > 8'h39 || ch_lo < 8'h30 || ch_lo > 8'h39) begin
            ok = 0;
            v[k] = 0;
         end else begin
            v[k] = (ch_hi - 8'h30) * 10 + (ch_lo - 8'h30);
         end
      end
      day  = v[0];
      mon  = v[1];
      year = int'(gutld_pkg::YEAR_BASE) + v[2];
      hour = v[3];
      if (ok && (mon < 1 || mon > 12 || day < 1 || day > month_length(mon, year) ||
                 hour > 23 || v[4] > 59 || v[5] > 59))
         ok = 0;
      if (!ok) begin
         bad_inputs++;
         return r;
      end
      good_inputs++;
      hour = hour + zone;
      if (hour < 0) begin
         days_back++;
         hour += 24;
         day--;
         if (day == 0) begin
            mon--;
            if (mon == 0) begin
               mon = 12;
               year--;
            end
            day = month_length(mon, year);
         end
      end else if (hour >= 24) begin
         days_fwd++;
         hour -= 24;
         day++;
         if (day > month_length(mon, year)) begin
            day = 1;
            mon++;
            if (mon > 12) begin
               mon = 1;
               year++;
            end
         end
      end
      r.local_day    = 5'(day);
      r.local_month  = 4'(mon);
      r.local_year   = 12'(year);
      r.local_hour   = 5'(hour);
      r.local_minute = 6'(v[4]);
      r.local_second = 6'(v[5]);
      r.input_ok     = 1'b1;
      return r;
   endfunction

   function void note_request(logic [47:0] dt, logic [47:0] tt);
      due_q.push_back(localize(dt, tt));
   endfunction

   function int pending();
      return due_q.size();
   endfunction

   task report(string what);
      if (errors < 30) $display("mismatch at %0t: %s", $time, what);
      errors++;
   endtask

   task compare_field(string name, int got, int want);
      if (got != want)
         report($sformatf("transaction %0d %s got %0d expected %0d", checked, name, got, want));
   endtask

   task check_result(gutld_pkg::result_type got);
      gutld_pkg::result_type want;
      if (due_q.size() == 0) begin
         report("response with no transaction outstanding");
         return;
      end
      want = due_q.pop_front();
      compare_field("local_day",    got.local_day,    want.local_day);
      compare_field("local_month",  got.local_month,  want.local_month);
      compare_field("local_year",   got.local_year,   want.local_year);
      compare_field("local_hour",   got.local_hour,   want.local_hour);
      compare_field("local_minute", got.local_minute, want.local_minute);
      compare_field("local_second", got.local_second, want.local_second);
      compare_field("input_ok",     got.input_ok,     want.input_ok);
      checked++;
   endtask

   task finish_check();
      if (due_q.size() != 0)
         report($sformatf("%0d responses never arrived", due_q.size()));
   endtask
endclass

module gps_utc_to_local_datetime_top_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 135;
   localparam int NUM_PHASES   = 10;
   localparam int STEADY_PHASE = 4;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic signed [gutld_pkg::OFFSET_W-1:0] csr_wr_data;
   bit steady;
   int cycles;
   int zone_writes;

   gutld_req_if req_bus();
   gutld_rsp_if rsp_bus();

   tz_scoreboard sb;

   gps_utc_to_local_datetime_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 30);
   end

   // accepted transactions on both sides
   always @(posedge clock) begin
      gutld_pkg::result_type got;
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(req_bus.date_text, req_bus.time_text);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.local_day    = rsp_bus.local_day;
         got.local_month  = rsp_bus.local_month;
         got.local_year   = rsp_bus.local_year;
         got.local_hour   = rsp_bus.local_hour;
         got.local_minute = rsp_bus.local_minute;
         got.local_second = rsp_bus.local_second;
         got.input_ok     = rsp_bus.input_ok;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [47:0] as_text(int a, int b, int c);
      return {8'(8'h30 + a / 10), 8'(8'h30 + a % 10),
              8'(8'h30 + b / 10), 8'(8'h30 + b % 10),
              8'(8'h30 + c / 10), 8'(8'h30 + c % 10)};
   endfunction

   // called just after a falling edge, returns just after a falling edge once the request has been accepted
   task automatic send(logic [47:0] dt, logic [47:0] tt);
      while (!steady && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.date_text <= dt;
      req_bus.time_text <= tt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_zone(int hours);
      req_bus.valid <= 1'b0;
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= 5'(hours);
      @(posedge clock);
      sb.zone = 5'(hours);
      zone_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly well-formed timestamps near carry points, some broken ones
   task automatic random_item(output logic [47:0] dt, output logic [47:0] tt);
      int pick, yy, mm, dd, hh, mi, ss, len, k;
      pick = $urandom_range(99);
      yy = $urandom_range(99);
      mm = $urandom_range(1, 12);
      if ($urandom_range(9) == 0) begin
         yy = $urandom_range(1) ? 99 : 0;
         mm = $urandom_range(1) ? 12 : 1;
      end
      len = sb.month_length(mm, 2000 + yy);
      case ($urandom_range(2))
         0: dd = 1;
         1: dd = len;
         default: dd = $urandom_range(1, len);
      endcase
      hh = $urandom_range(1) ? $urandom_range(23) :
           ($urandom_range(1) ? $urandom_range(3) : $urandom_range(20, 23));
      mi = $urandom_range(59);
      ss = $urandom_range(59);
      if (pick >= 80 && pick < 90) begin
         case ($urandom_range(4))
            0: mm = $urandom_range(1) ? 0 : $urandom_range(13, 99);
            1: dd = $urandom_range(1) ? 0 : $urandom_range(len + 1, 99);
            2: hh = $urandom_range(24, 99);
            3: mi = $urandom_range(60, 99);
            default: ss = $urandom_range(60, 99);
         endcase
      end
      dt = as_text(dd, mm, yy);
      tt = as_text(hh, mi, ss);
      if (pick >= 90 && pick < 96) begin
         k = $urandom_range(11);
         if (k < 6) dt[8*k +: 8] = 8'($urandom_range(255));
         else       tt[8*(k-6) +: 8] = 8'($urandom_range(255));
      end else if (pick >= 96) begin
         dt = {16'($urandom), 32'($urandom)};
         tt = {16'($urandom), 32'($urandom)};
      end
   endtask

   initial begin
      int phase_zone[NUM_PHASES] = '{0, -12, 14, -16, 15, 3, -5, 9, -1, 1};
      int p, n;
      logic [47:0] dt, tt;
      sb = new();
      reset             = 1'b1;
      steady            = 1'b0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.date_text = '0;
      req_bus.time_text = '0;
      rsp_bus.ready     = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset offset: range checks, bad characters, leap day in 2000
      send("000000", "000000");
      send("311299", "235959");
      send("290200", "120000");
      send("290201", "120000");
      send("310400", "000000");
      send("011300", "000000");
      send("320100", "000000");
      send("150699", "240000");
      send("150699", "236000");
      send("150699", "235960");
      send("1506/9", "000000");
      send("150699", "00:000");
      send("999999", "999999");
      // most negative offset: back across year 2000, leap and plain february
      set_zone(-16);
      send("010100", "000000");
      send("010324", "100000");
      send("010323", "050000");
      send("010500", "153030");
      // most positive offset: forward into 2100 and across end of february
      set_zone(15);
      send("311299", "230000");
      send("280224", "100000");
      send("290224", "090000");
      send("300600", "085959");
      set_zone(14);
      send("311298", "100000");
      set_zone(-12);
      send("010198", "115959");
      set_zone(-1);
      send("010199", "000000");

      for (p = 0; p < NUM_PHASES; p++) begin
         set_zone(phase_zone[p]);
         steady = (p == STEADY_PHASE);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            random_item(dt, tt);
            send(dt, tt);
         end
         steady = 1'b0;
      end
      req_bus.valid <= 1'b0;

      drain();
      repeat (8) @(posedge clock);
      sb.finish_check();
      $display("checked %0d responses: %0d valid timestamps, %0d rejected",
               sb.checked, sb.good_inputs, sb.bad_inputs);
      $display("%0d carried back a day, %0d forward, over %0d offset settings",
               sb.days_back, sb.days_fwd, zone_writes + 1);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ files.f @@
hdl/gutld_pkg.sv
hdl/gutld_if.sv
hdl/gutld_carry.sv
hdl/gps_utc_to_local_datetime_top.sv
hdl/gutld_checker.sv
tb/gps_utc_to_local_datetime_top_tb.sv
